FILE: design/tagged_double_word_codec_core_assert.svh
// Assertion macros for the tagged double word codec core.
`ifndef TAGGED_DOUBLE_WORD_CODEC_CORE_ASSERT_SVH
`define TAGGED_DOUBLE_WORD_CODEC_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TDWC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("tdwc: %s failed", "lbl");

// Next-cycle implication, checked out of reset.
`define TDWC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdwc: %s failed", "lbl");

`endif

FILE: design/tdwc_pkg.sv
// Package: constants, power-of-ten table and helpers of the tagged double word codec.
package tdwc_pkg;

    localparam int unsigned WordW  = 64;
    localparam int unsigned ValW   = 56;
    localparam int unsigned CoefW  = 48;
    localparam int unsigned SigW   = 53;
    localparam int unsigned ExpW   = 11;
    localparam int unsigned LzW    = 6;

    localparam logic [7:0]  TYPE_INT = 8'h01;
    localparam logic [7:0]  TYPE_DEC = 8'h02;
    localparam logic [63:0] TAG_INT  = 64'h0100_0000_0000_0000;
    localparam logic [10:0] EXP_BIAS = 11'd1023;
    localparam logic [10:0] EXP_MAXI = 11'd1085;
    localparam logic        CMD_ENC  = 1'b0;

    // Nearest double to 10^e, indexed by e + 128
    localparam logic [63:0] POW10_TAB [256] = '{
        $realtobits(1e-128), $realtobits(1e-127), $realtobits(1e-126), $realtobits(1e-125),
        $realtobits(1e-124), $realtobits(1e-123), $realtobits(1e-122), $realtobits(1e-121),
        $realtobits(1e-120), $realtobits(1e-119), $realtobits(1e-118), $realtobits(1e-117),
        $realtobits(1e-116), $realtobits(1e-115), $realtobits(1e-114), $realtobits(1e-113),
        $realtobits(1e-112), $realtobits(1e-111), $realtobits(1e-110), $realtobits(1e-109),
        $realtobits(1e-108), $realtobits(1e-107), $realtobits(1e-106), $realtobits(1e-105),
        $realtobits(1e-104), $realtobits(1e-103), $realtobits(1e-102), $realtobits(1e-101),
        $realtobits(1e-100), $realtobits(1e-99), $realtobits(1e-98), $realtobits(1e-97),
        $realtobits(1e-96), $realtobits(1e-95), $realtobits(1e-94), $realtobits(1e-93),
        $realtobits(1e-92), $realtobits(1e-91), $realtobits(1e-90), $realtobits(1e-89),
        $realtobits(1e-88), $realtobits(1e-87), $realtobits(1e-86), $realtobits(1e-85),
        $realtobits(1e-84), $realtobits(1e-83), $realtobits(1e-82), $realtobits(1e-81),
        $realtobits(1e-80), $realtobits(1e-79), $realtobits(1e-78), $realtobits(1e-77),
        $realtobits(1e-76), $realtobits(1e-75), $realtobits(1e-74), $realtobits(1e-73),
        $realtobits(1e-72), $realtobits(1e-71), $realtobits(1e-70), $realtobits(1e-69),
        $realtobits(1e-68), $realtobits(1e-67), $realtobits(1e-66), $realtobits(1e-65),
        $realtobits(1e-64), $realtobits(1e-63), $realtobits(1e-62), $realtobits(1e-61),
        $realtobits(1e-60), $realtobits(1e-59), $realtobits(1e-58), $realtobits(1e-57),
        $realtobits(1e-56), $realtobits(1e-55), $realtobits(1e-54), $realtobits(1e-53),
        $realtobits(1e-52), $realtobits(1e-51), $realtobits(1e-50), $realtobits(1e-49),
        $realtobits(1e-48), $realtobits(1e-47), $realtobits(1e-46), $realtobits(1e-45),
        $realtobits(1e-44), $realtobits(1e-43), $realtobits(1e-42), $realtobits(1e-41),
        $realtobits(1e-40), $realtobits(1e-39), $realtobits(1e-38), $realtobits(1e-37),
        $realtobits(1e-36), $realtobits(1e-35), $realtobits(1e-34), $realtobits(1e-33),
        $realtobits(1e-32), $realtobits(1e-31), $realtobits(1e-30), $realtobits(1e-29),
        $realtobits(1e-28), $realtobits(1e-27), $realtobits(1e-26), $realtobits(1e-25),
        $realtobits(1e-24), $realtobits(1e-23), $realtobits(1e-22), $realtobits(1e-21),
        $realtobits(1e-20), $realtobits(1e-19), $realtobits(1e-18), $realtobits(1e-17),
        $realtobits(1e-16), $realtobits(1e-15), $realtobits(1e-14), $realtobits(1e-13),
        $realtobits(1e-12), $realtobits(1e-11), $realtobits(1e-10), $realtobits(1e-9),
        $realtobits(1e-8), $realtobits(1e-7), $realtobits(1e-6), $realtobits(1e-5),
        $realtobits(1e-4), $realtobits(1e-3), $realtobits(1e-2), $realtobits(1e-1),
        $realtobits(1e0), $realtobits(1e1), $realtobits(1e2), $realtobits(1e3),
        $realtobits(1e4), $realtobits(1e5), $realtobits(1e6), $realtobits(1e7),
        $realtobits(1e8), $realtobits(1e9), $realtobits(1e10), $realtobits(1e11),
        $realtobits(1e12), $realtobits(1e13), $realtobits(1e14), $realtobits(1e15),
        $realtobits(1e16), $realtobits(1e17), $realtobits(1e18), $realtobits(1e19),
        $realtobits(1e20), $realtobits(1e21), $realtobits(1e22), $realtobits(1e23),
        $realtobits(1e24), $realtobits(1e25), $realtobits(1e26), $realtobits(1e27),
        $realtobits(1e28), $realtobits(1e29), $realtobits(1e30), $realtobits(1e31),
        $realtobits(1e32), $realtobits(1e33), $realtobits(1e34), $realtobits(1e35),
        $realtobits(1e36), $realtobits(1e37), $realtobits(1e38), $realtobits(1e39),
        $realtobits(1e40), $realtobits(1e41), $realtobits(1e42), $realtobits(1e43),
        $realtobits(1e44), $realtobits(1e45), $realtobits(1e46), $realtobits(1e47),
        $realtobits(1e48), $realtobits(1e49), $realtobits(1e50), $realtobits(1e51),
        $realtobits(1e52), $realtobits(1e53), $realtobits(1e54), $realtobits(1e55),
        $realtobits(1e56), $realtobits(1e57), $realtobits(1e58), $realtobits(1e59),
        $realtobits(1e60), $realtobits(1e61), $realtobits(1e62), $realtobits(1e63),
        $realtobits(1e64), $realtobits(1e65), $realtobits(1e66), $realtobits(1e67),
        $realtobits(1e68), $realtobits(1e69), $realtobits(1e70), $realtobits(1e71),
        $realtobits(1e72), $realtobits(1e73), $realtobits(1e74), $realtobits(1e75),
        $realtobits(1e76), $realtobits(1e77), $realtobits(1e78), $realtobits(1e79),
        $realtobits(1e80), $realtobits(1e81), $realtobits(1e82), $realtobits(1e83),
        $realtobits(1e84), $realtobits(1e85), $realtobits(1e86), $realtobits(1e87),
        $realtobits(1e88), $realtobits(1e89), $realtobits(1e90), $realtobits(1e91),
        $realtobits(1e92), $realtobits(1e93), $realtobits(1e94), $realtobits(1e95),
        $realtobits(1e96), $realtobits(1e97), $realtobits(1e98), $realtobits(1e99),
        $realtobits(1e100), $realtobits(1e101), $realtobits(1e102), $realtobits(1e103),
        $realtobits(1e104), $realtobits(1e105), $realtobits(1e106), $realtobits(1e107),
        $realtobits(1e108), $realtobits(1e109), $realtobits(1e110), $realtobits(1e111),
        $realtobits(1e112), $realtobits(1e113), $realtobits(1e114), $realtobits(1e115),
        $realtobits(1e116), $realtobits(1e117), $realtobits(1e118), $realtobits(1e119),
        $realtobits(1e120), $realtobits(1e121), $realtobits(1e122), $realtobits(1e123),
        $realtobits(1e124), $realtobits(1e125), $realtobits(1e126), $realtobits(1e127)
    };

    // Count leading zeros of a 56-bit magnitude (zero input gives 55)
    function automatic logic [LzW-1:0] lzc56(input logic [ValW-1:0] m);
        logic [LzW-1:0] n;
        n = LzW'(ValW - 1);
        for (int i = 0; i < ValW; i++) begin
            if (m[i]) begin
                n = LzW'(ValW - 1 - i);
            end
        end
        return n;
    endfunction

endpackage

FILE: design/tagged_double_word_codec_core.sv
// Tagged double word codec: encode doubles to tagged words, decode tagged words to doubles.
//
// Usage:
//   Drive cmd and word_in with start high for one cycle to transfer an item;
//   cmd 0 encodes double bits, cmd 1 decodes a tagged word. busy is always low,
//   so a new item may be started in every cycle.
//   Each item gives one result: word_out and certain are valid for exactly
//   one cycle while done is high; the receiver cannot stall the block.
// Pipeline:
//   Six register stages, and one item per cycle is sustained. The depth is
//   set by the decode datapath: input register, operand prep and table read,
//   leading-zero normalise, four partial products, product sum, and rounding
//   into the output register.
// Reset:
//   rst_n clears all valid bits and done; items in flight are dropped.
`include "tagged_double_word_codec_core_assert.svh"

module tagged_double_word_codec_core
    import tdwc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              cmd,
    input  logic [WordW-1:0]  word_in,
    output logic              done,
    output logic [WordW-1:0]  word_out,
    output logic              certain
);

    // Stage 1: input register
    logic             v1_reg;
    logic             cmd1_reg;
    logic [WordW-1:0] w1_reg;

    // Stage 2: classified operands
    logic             v2_reg, mul2_reg, sgn2_reg, cmd2_reg;
    logic             enc_zero2_reg, enc_int2_reg;
    logic [62:0]      enc_mag2_reg;
    logic [WordW-1:0] w2_reg;
    logic [ValW-1:0]  m2_reg;
    logic [SigW-1:0]  mp2_reg;
    logic [ExpW-1:0]  ep2_reg;

    // Stage 3: normalised operands, direct results
    logic             v3_reg, mul3_reg, sgn3_reg, zero3_reg, dok3_reg;
    logic [WordW-1:0] dres3_reg;
    logic [ValW-1:0]  mn3_reg;
    logic [SigW-1:0]  mp3_reg;
    logic [11:0]      eb3_reg;

    // Stage 4: partial products
    logic             v4_reg, mul4_reg, sgn4_reg, zero4_reg, dok4_reg;
    logic [WordW-1:0] dres4_reg;
    logic [53:0]      pp_hh4_reg, pp_lh4_reg;
    logic [54:0]      pp_hl4_reg, pp_ll4_reg;
    logic [11:0]      eb4_reg;

    // Stage 5: full product
    logic             v5_reg, mul5_reg, sgn5_reg, zero5_reg, dok5_reg;
    logic [WordW-1:0] dres5_reg;
    logic [108:0]     p5_reg;
    logic [11:0]      eb5_reg;

    // Output register
    logic             done_reg, certain_reg;
    logic [WordW-1:0] word_out_reg;

    // Stage 1 -> 2 combinational
    logic [10:0]      s1_expf;
    logic             s1_enc_zero, s1_enc_rng, s1_enc_int;
    logic [LzW-1:0]   s1_enc_sh;
    logic [114:0]     s1_enc_z;
    logic [7:0]       s1_type;
    logic [63:0]      s1_tab;
    logic             s1_is_int, s1_is_dec;
    logic [ValW-1:0]  s1_int_mag;
    logic [CoefW-1:0] s1_coef_mag;

    always_comb
    begin
        s1_expf     = w1_reg[62:52];
        s1_enc_zero = (s1_expf == '0) && (w1_reg[51:0] == '0);
        s1_enc_rng  = (s1_expf >= EXP_BIAS) && (s1_expf <= EXP_MAXI);
        s1_enc_sh   = LzW'(s1_expf - EXP_BIAS);
        s1_enc_z    = {62'b0, 1'b1, w1_reg[51:0]} << s1_enc_sh;
        s1_enc_int  = s1_enc_rng && (s1_enc_z[51:0] == '0);
        s1_type     = w1_reg[63:56];
        s1_tab      = POW10_TAB[w1_reg[55:48] ^ 8'h80];
        s1_is_int   = (cmd1_reg != CMD_ENC) && (s1_type == TYPE_INT);
        s1_is_dec   = (cmd1_reg != CMD_ENC) && (s1_type == TYPE_DEC);
        s1_int_mag  = w1_reg[55] ? (~w1_reg[55:0] + ValW'(1)) : w1_reg[55:0];
        s1_coef_mag = w1_reg[47] ? (~w1_reg[47:0] + CoefW'(1)) : w1_reg[47:0];
    end

    // Stage 2 -> 3 combinational
    logic [LzW-1:0]   s2_lz;
    logic [WordW-1:0] s2_neg, s2_dres;
    logic             s2_dok;

    always_comb
    begin
        s2_lz  = lzc56(m2_reg);
        s2_neg = w2_reg[63] ? (~{1'b0, enc_mag2_reg} + WordW'(1)) : {1'b0, enc_mag2_reg};
        s2_dok = 1'b1;
        if (cmd2_reg == CMD_ENC)
        begin
            if (enc_zero2_reg)
                s2_dres = TAG_INT;
            else if (enc_int2_reg)
                s2_dres = {TYPE_INT, s2_neg[55:0]};
            else
                s2_dres = {1'b1, w2_reg[63:1]};
        end
        else if (w2_reg[63])
        begin
            s2_dres = {w2_reg[62:0], 1'b0};
        end
        else
        begin
            s2_dres = '0;
            s2_dok  = 1'b0;
        end
    end

    // Stage 5 -> output combinational: round to nearest even
    logic [51:0]      s5_frac;
    logic             s5_guard, s5_sticky, s5_inc;
    logic [10:0]      s5_exp;
    logic [WordW-1:0] s5_res;

    always_comb
    begin
        if (p5_reg[108])
        begin
            s5_frac   = p5_reg[107:56];
            s5_guard  = p5_reg[55];
            s5_sticky = |p5_reg[54:0];
            s5_exp    = 11'(eb5_reg + 12'd1);
        end
        else
        begin
            s5_frac   = p5_reg[106:55];
            s5_guard  = p5_reg[54];
            s5_sticky = |p5_reg[53:0];
            s5_exp    = 11'(eb5_reg);
        end
        s5_inc = s5_guard && (s5_sticky || s5_frac[0]);
        s5_res = {sgn5_reg, s5_exp, s5_frac} + WordW'(s5_inc);
    end

    // Advance the pipeline every cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            done_reg <= v5_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        // hold the transfer
        cmd1_reg <= cmd;
        w1_reg   <= word_in;

        // classify and prepare multiplier operands
        cmd2_reg      <= cmd1_reg;
        w2_reg        <= w1_reg;
        enc_zero2_reg <= s1_enc_zero;
        enc_int2_reg  <= s1_enc_int;
        enc_mag2_reg  <= s1_enc_z[114:52];
        mul2_reg      <= s1_is_int || s1_is_dec;
        sgn2_reg      <= s1_is_int ? w1_reg[55] : w1_reg[47];
        m2_reg        <= s1_is_int ? s1_int_mag : {8'b0, s1_coef_mag};
        mp2_reg       <= s1_is_int ? {1'b1, 52'b0} : {1'b1, s1_tab[51:0]};
        ep2_reg       <= s1_is_int ? EXP_BIAS : s1_tab[62:52];

        // normalise the integer operand
        mul3_reg  <= mul2_reg;
        sgn3_reg  <= sgn2_reg;
        zero3_reg <= (m2_reg == '0);
        mn3_reg   <= m2_reg << s2_lz;
        mp3_reg   <= mp2_reg;
        eb3_reg   <= 12'(ep2_reg) + 12'd55 - 12'(s2_lz);
        dres3_reg <= s2_dres;
        dok3_reg  <= s2_dok;

        // split the product into four partial products
        mul4_reg   <= mul3_reg;
        sgn4_reg   <= sgn3_reg;
        zero4_reg  <= zero3_reg;
        eb4_reg    <= eb3_reg;
        dres4_reg  <= dres3_reg;
        dok4_reg   <= dok3_reg;
        pp_hh4_reg <= mn3_reg[55:28] * mp3_reg[52:27];
        pp_hl4_reg <= mn3_reg[55:28] * mp3_reg[26:0];
        pp_lh4_reg <= mn3_reg[27:0] * mp3_reg[52:27];
        pp_ll4_reg <= mn3_reg[27:0] * mp3_reg[26:0];

        // sum the partial products
        mul5_reg  <= mul4_reg;
        sgn5_reg  <= sgn4_reg;
        zero5_reg <= zero4_reg;
        eb5_reg   <= eb4_reg;
        dres5_reg <= dres4_reg;
        dok5_reg  <= dok4_reg;
        p5_reg    <= ({55'b0, pp_hh4_reg} << 55) + ({54'b0, pp_hl4_reg} << 28)
                   + ({55'b0, pp_lh4_reg} << 27) + {54'b0, pp_ll4_reg};

        // round and select the result
        if (!mul5_reg)
        begin
            word_out_reg <= dres5_reg;
            certain_reg  <= dok5_reg;
        end
        else
        begin
            word_out_reg <= zero5_reg ? '0 : s5_res;
            certain_reg  <= 1'b1;
        end
    end

    assign busy     = 1'b0;
    assign done     = done_reg;
    assign word_out = word_out_reg;
    assign certain  = certain_reg;

    // Checks
    `TDWC_ASSERT_NEXT(a_enter, start, v1_reg)
    `TDWC_ASSERT_IMPL(a_latency, start, ##6 done)
    `TDWC_ASSERT_IMPL(a_unknown_zero, done && !certain, (word_out == '0))
    `TDWC_ASSERT_IMPL(a_done_source, done, $past(v5_reg))

endmodule
